// ----- rtl/hit_energy_centroid_accumulator_core_defines.svh -----
// Assertion macros shared by the accumulator RTL.
`ifndef HIT_ENERGY_CENTROID_ACCUMULATOR_CORE_DEFINES_SVH
`define HIT_ENERGY_CENTROID_ACCUMULATOR_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define HEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HEC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HEC_ASSERT(lbl, prop, msg)
`define HEC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/hec_pkg.sv -----
// Shared types and constants of the centroid accumulator.
package hec_pkg;
  localparam int ENTRIES_DEF = 512;
  localparam int ID_W   = 15;
  localparam int E_W    = 40;
  localparam int HE_W   = 32;
  localparam int POS_W  = 24;
  localparam int PROD_W = 57;
  localparam int TOT_W  = 41;
  localparam logic [E_W-1:0] E_MAX = {E_W{1'b1}};

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [E_W-1:0]   energy;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
  } hec_entry_t;
endpackage

// ----- rtl/hit_energy_centroid_accumulator_core.sv -----
// Top level of the energy-weighted hit centroid accumulator.
//
// Usage: requests enter on the in_ valid/ready channel, one result per
// request leaves on the out_ valid/ready channel. Request types: add hit,
// read entry, clear table.
// The table is a ring of MAX_ENTRIES cells that rotates one position per
// cycle while a request seeks its entry; only the cell at the head is looked
// at or written, and a head index tracks which entry sits there.
// Flow, from the accepting edge to out_valid: an add walks the ring until the
// channel turns up (divide products formed on the way), then either seeks
// the append position or runs three parallel bit-serial dividers. The worst
// add is set by ring rotation. A read walks the ring to its slot; clear or a
// bad read goes straight to the result.
// One request is in work at a time; in_ready is high only while idle.
// A finished result sits in the output register; if the receiver stalls,
// a following request can be taken and worked, and its result waits until
// the output register is free.
// Reset clears the entry count, the state and the output valid; the cell
// contents are not cleared and are never read before being written.
module hit_energy_centroid_accumulator_core
  import hec_pkg::*;
#(
  parameter int MAX_ENTRIES = ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [ID_W-1:0]   in_chan_id,
  input  logic [HE_W-1:0]   in_hit_energy,
  input  logic [POS_W-1:0]  in_hit_x,
  input  logic [POS_W-1:0]  in_hit_y,
  input  logic [POS_W-1:0]  in_hit_z,
  input  logic [8:0]        in_read_slot,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [8:0]        out_slot,
  output logic              out_is_new,
  output logic              out_table_full,
  output logic              out_bad_slot,
  output logic [ID_W-1:0]   out_chan_id,
  output logic [E_W-1:0]    out_energy_sum,
  output logic [POS_W-1:0]  out_centroid_x,
  output logic [POS_W-1:0]  out_centroid_y,
  output logic [POS_W-1:0]  out_centroid_z,
  output logic [9:0]        out_entry_count
);
`include "hit_energy_centroid_accumulator_core_defines.svh"

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_APPEND = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_MUL    = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  // combine the divider result with the stored coordinate
  function automatic logic [POS_W-1:0] fin_axis(
    input logic [POS_W-1:0]  old,
    input logic [POS_W-1:0]  p,
    input logic              neg,
    input logic [PROD_W-1:0] quo,
    input logic              remnz,
    input logic              tz
  );
    logic signed [27:0] q;
    logic signed [27:0] fl;
    q = signed'({2'b00, quo[25:0]});
    if (neg) begin
      q = -(q + 28'(remnz));
    end
    fl = signed'({{4{old[POS_W-1]}}, old}) + q;
    if (remnz && fl[27]) begin
      fl = fl + 28'sd1;
    end
    return tz ? p : fl[POS_W-1:0];
  endfunction

  logic [2:0]       state_r, state_nxt;
  logic [IW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    used_r, used_nxt;
  logic [CW-1:0]    steps_r, steps_nxt;

  // latched request
  logic [1:0]       req_r;
  logic [ID_W-1:0]  cid_r;
  logic [HE_W-1:0]  e_r;
  logic [POS_W-1:0] px_r, py_r, pz_r;
  logic [8:0]       rs_r;

  // multiply stage
  logic [PROD_W-1:0] prod_x_r, prod_y_r, prod_z_r;
  logic              neg_x_r, neg_y_r, neg_z_r;
  logic [TOT_W-1:0]  tot_r;

  // pending result
  logic [8:0]        res_slot_r, res_slot_nxt;
  logic              res_new_r, res_new_nxt;
  logic              res_full_r, res_full_nxt;
  logic              res_bad_r, res_bad_nxt;
  logic              res_ent_r, res_ent_nxt;  // entry fields valid
  hec_entry_t        res_e_r, res_e_nxt;

  // output register
  logic              out_valid_r;
  logic [8:0]        o_slot_r;
  logic              o_new_r, o_full_r, o_bad_r;
  hec_entry_t        o_e_r;
  logic [9:0]        o_cnt_r;

  logic              shift;
  logic              wr;
  hec_entry_t        wr_data;
  hec_entry_t        cq [MAX_ENTRIES];
  hec_entry_t        head_e;

  logic              div_start;
  logic              busy_x, busy_y, busy_z;
  logic [PROD_W-1:0] quo_x, quo_y, quo_z;
  logic [TOT_W-1:0]  rem_x, rem_y, rem_z;

  logic              hit;
  logic [IW-1:0]     head_inc;
  logic [POS_W:0]    dx, dy, dz;
  logic [POS_W:0]    mx, my, mz;
  logic              tz;
  hec_entry_t        upd_e;
  logic              out_free;

  assign head_e   = cq[0];
  assign head_inc = (head_r == IW'(MAX_ENTRIES - 1)) ? '0 : head_r + 1'b1;
  assign hit      = (CW'(head_r) < used_r) && (head_e.id == cid_r);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  // ring of entry cells; cell i takes its right neighbor, the last wraps
  for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
    hec_cell u_cell (
      .clk       (clk),
      .shift_i   (shift),
      .wr_i      (wr && (gi == 0)),
      .nb_i      (cq[(gi + 1) % MAX_ENTRIES]),
      .wr_data_i (wr_data),
      .q_o       (cq[gi])
    );
  end

  hec_div #(.DW(PROD_W), .VW(TOT_W)) u_div_x (
    .clk(clk), .rst_n(rst_n), .start_i(div_start), .dividend_i(prod_x_r),
    .divisor_i(tot_r), .busy_o(busy_x), .quo_o(quo_x), .rem_o(rem_x)
  );
  hec_div #(.DW(PROD_W), .VW(TOT_W)) u_div_y (
    .clk(clk), .rst_n(rst_n), .start_i(div_start), .dividend_i(prod_y_r),
    .divisor_i(tot_r), .busy_o(busy_y), .quo_o(quo_y), .rem_o(rem_y)
  );
  hec_div #(.DW(PROD_W), .VW(TOT_W)) u_div_z (
    .clk(clk), .rst_n(rst_n), .start_i(div_start), .dividend_i(prod_z_r),
    .divisor_i(tot_r), .busy_o(busy_z), .quo_o(quo_z), .rem_o(rem_z)
  );

  // signed difference and magnitude per axis
  assign dx = {px_r[POS_W-1], px_r} - {head_e.x[POS_W-1], head_e.x};
  assign dy = {py_r[POS_W-1], py_r} - {head_e.y[POS_W-1], head_e.y};
  assign dz = {pz_r[POS_W-1], pz_r} - {head_e.z[POS_W-1], head_e.z};
  assign mx = dx[POS_W] ? -dx : dx;
  assign my = dy[POS_W] ? -dy : dy;
  assign mz = dz[POS_W] ? -dz : dz;

  assign tz = (tot_r == '0);
  always_comb begin
    upd_e        = head_e;
    upd_e.x      = fin_axis(head_e.x, px_r, neg_x_r, quo_x, rem_x != '0, tz);
    upd_e.y      = fin_axis(head_e.y, py_r, neg_y_r, quo_y, rem_y != '0, tz);
    upd_e.z      = fin_axis(head_e.z, pz_r, neg_z_r, quo_z, rem_z != '0, tz);
    upd_e.energy = tot_r[TOT_W-1] ? E_MAX : tot_r[E_W-1:0];
  end

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    used_nxt     = used_r;
    steps_nxt    = steps_r;
    res_slot_nxt = res_slot_r;
    res_new_nxt  = res_new_r;
    res_full_nxt = res_full_r;
    res_bad_nxt  = res_bad_r;
    res_ent_nxt  = res_ent_r;
    res_e_nxt    = res_e_r;
    shift        = 1'b0;
    wr           = 1'b0;
    wr_data      = upd_e;
    div_start    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_slot_nxt = '0;
          res_new_nxt  = 1'b0;
          res_full_nxt = 1'b0;
          res_bad_nxt  = 1'b0;
          res_ent_nxt  = 1'b0;
          steps_nxt    = '0;
          case (in_req_type)
            REQ_ADD:   state_nxt = (used_r == '0) ? ST_APPEND : ST_SCAN;
            REQ_READ: begin
              if (16'(in_read_slot) < 16'(used_r)) begin
                state_nxt = ST_READ;
              end else begin
                res_slot_nxt = in_read_slot;
                res_bad_nxt  = 1'b1;
                state_nxt    = ST_DONE;
              end
            end
            REQ_CLEAR: begin
              used_nxt  = '0;
              state_nxt = ST_DONE;
            end
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_nxt = ST_MUL;
        end else begin
          shift     = 1'b1;
          head_nxt  = head_inc;
          steps_nxt = steps_r + 1'b1;
          if (steps_r == CW'(MAX_ENTRIES - 1)) begin
            state_nxt = ST_APPEND;
          end
        end
      end
      ST_APPEND: begin
        if (used_r == CW'(MAX_ENTRIES)) begin
          res_full_nxt = 1'b1;
          state_nxt    = ST_DONE;
        end else if (CW'(head_r) == used_r) begin
          wr             = 1'b1;
          wr_data.id     = cid_r;
          wr_data.energy = E_W'(e_r);
          wr_data.x      = px_r;
          wr_data.y      = py_r;
          wr_data.z      = pz_r;
          used_nxt       = used_r + 1'b1;
          res_slot_nxt   = 9'(head_r);
          res_new_nxt    = 1'b1;
          res_ent_nxt    = 1'b1;
          res_e_nxt      = wr_data;
          state_nxt      = ST_DONE;
        end else begin
          shift    = 1'b1;
          head_nxt = head_inc;
        end
      end
      ST_READ: begin
        if (16'(head_r) == 16'(rs_r)) begin
          res_slot_nxt = rs_r;
          res_ent_nxt  = 1'b1;
          res_e_nxt    = head_e;
          state_nxt    = ST_DONE;
        end else begin
          shift    = 1'b1;
          head_nxt = head_inc;
        end
      end
      ST_MUL: begin
        // products of the hit entry are already registered
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!busy_x) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        wr           = 1'b1;
        res_slot_nxt = 9'(head_r);
        res_ent_nxt  = 1'b1;
        res_e_nxt    = upd_e;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      used_r  <= '0;
      steps_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      used_r  <= used_nxt;
      steps_r <= steps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_slot_r <= res_slot_nxt;
    res_new_r  <= res_new_nxt;
    res_full_r <= res_full_nxt;
    res_bad_r  <= res_bad_nxt;
    res_ent_r  <= res_ent_nxt;
    res_e_r    <= res_e_nxt;
    if (state_r == ST_IDLE && in_valid) begin
      req_r <= in_req_type;
      cid_r <= in_chan_id;
      e_r   <= in_hit_energy;
      px_r  <= in_hit_x;
      py_r  <= in_hit_y;
      pz_r  <= in_hit_z;
      rs_r  <= in_read_slot;
    end
    // head does not move on a hit, so the last scan cycle holds its products
    if (state_r == ST_SCAN) begin
      prod_x_r <= e_r * mx;
      prod_y_r <= e_r * my;
      prod_z_r <= e_r * mz;
      neg_x_r  <= dx[POS_W];
      neg_y_r  <= dy[POS_W];
      neg_z_r  <= dz[POS_W];
      tot_r    <= TOT_W'(head_e.energy) + TOT_W'(e_r);
    end
  end

  // output register: loaded from the pending result once it is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      o_slot_r <= res_slot_r;
      o_new_r  <= res_new_r;
      o_full_r <= res_full_r;
      o_bad_r  <= res_bad_r;
      o_e_r    <= res_ent_r ? res_e_r : '0;
      o_cnt_r  <= 10'(used_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_slot        = o_slot_r;
  assign out_is_new      = o_new_r;
  assign out_table_full  = o_full_r;
  assign out_bad_slot    = o_bad_r;
  assign out_chan_id     = o_e_r.id;
  assign out_energy_sum  = o_e_r.energy;
  assign out_centroid_x  = o_e_r.x;
  assign out_centroid_y  = o_e_r.y;
  assign out_centroid_z  = o_e_r.z;
  assign out_entry_count = o_cnt_r;

  `HEC_ASSERT(a_count_bound, (used_r <= CW'(MAX_ENTRIES)), "entry count past table size")
  `HEC_ASSERT(a_flags_excl, (out_valid_r |-> !(o_new_r && o_full_r)), "new and full together")
  `HEC_ASSERT(a_div_in_wait, (busy_x |-> (state_r == ST_DIV)), "divider busy outside wait")
  `HEC_ASSERT(a_req_kept, ((state_r == ST_MUL) |-> (req_r == REQ_ADD)), "multiply on non-add")
  `HEC_ASSERT(a_div_lanes, (busy_x == busy_y && busy_y == busy_z), "divider lanes apart")
endmodule

// ----- rtl/hec_cell.sv -----
// One table entry cell of the rotating entry chain.
module hec_cell
  import hec_pkg::*;
(
  input  logic       clk,
  input  logic       shift_i,
  input  logic       wr_i,
  input  hec_entry_t nb_i,
  input  hec_entry_t wr_data_i,
  output hec_entry_t q_o
);
  hec_entry_t ent_r;

  always_ff @(posedge clk) begin
    if (wr_i) begin
      ent_r <= wr_data_i;
    end else if (shift_i) begin
      ent_r <= nb_i;
    end
  end

  assign q_o = ent_r;
endmodule

// ----- rtl/hec_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module hec_div #(
  parameter int DW = 57,
  parameter int VW = 41
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] quo_o,
  output logic [VW-1:0] rem_o
);
  localparam int NW = $clog2(DW + 1);

  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] div_r;
  logic [NW-1:0] cnt_r;
  logic          busy_r;
  logic [VW:0]   trial;
  logic [VW:0]   diff;

  assign trial = {rem_r, quo_r[DW-1]};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r  <= NW'(DW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == NW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      quo_r <= dividend_i;
      rem_r <= '0;
      div_r <= divisor_i;
    end else if (busy_r) begin
      if (!diff[VW]) begin
        rem_r <= diff[VW-1:0];
        quo_r <= {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= trial[VW-1:0];
        quo_r <= {quo_r[DW-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_r;
  assign quo_o  = quo_r;
  assign rem_o  = rem_r;
endmodule
